### src/hbs_pkg.sv
// Shared types, constants and helpers of the heightmap bilinear sampler.
package hbs_pkg;

  localparam int STORE_AW    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic REQ_WRITE = 1'b0;

  localparam logic [8:0]         MAP_DIM_RST   = 9'd256;
  localparam logic [30:0]        CELL_SIZE_RST = 31'd65536;
  localparam logic [30:0]        INV_CELL_RST  = 31'd65536;
  localparam logic signed [31:0] GAIN_RST      = 32'sd257;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MAP_WIDTH   = 3'd0,
    CFG_MAP_DEPTH   = 3'd1,
    CFG_CELL_SIZE   = 3'd2,
    CFG_INV_CELL    = 3'd3,
    CFG_HEIGHT_GAIN = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  typedef struct packed {
    logic                req_type;
    logic [15:0]         sample_index;
    logic [7:0]          sample_value;
    logic signed [31:0]  query_x;
    logic signed [31:0]  query_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0]  height_out;
    logic                map_loaded;
  } rsp_t;

  typedef struct packed {
    op_e                 op;
    logic [15:0]         sample_index;
    logic [7:0]          sample_value;
    logic signed [31:0]  query_x;
    logic signed [31:0]  query_z;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [8:0]          map_width;
    logic [8:0]          map_depth;
    logic [30:0]         cell_size;
    logic [30:0]         inv_cell_size;
    logic signed [31:0]  height_gain;
  } cfg_t;

  // Clamp a programmed grid dimension to the range 2 to mx.
  function automatic int unsigned eff_dim(logic [8:0] v, int unsigned mx);
    int unsigned r;
    r = 32'(v);
    if (r < 32'd2) begin
      r = 32'd2;
    end else if (r > mx) begin
      r = mx;
    end
    return r;
  endfunction

endpackage

### src/hbs_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface hbs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/hbs_front.sv
// Front end: accepts request beats, classifies them and tracks the loaded flag.
module hbs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  hbs_stream_if.sink       req_i,
  input  hbs_pkg::q_stat_t stat_i,
  output hbs_pkg::push_t   push_o
);
  import hbs_pkg::*;

  logic loaded_q, loaded_d;
  logic accept;
  logic is_write;

  assign req_i.ready = !stat_i.full;
  assign accept      = req_i.valid && req_i.ready;
  assign is_write    = (req_i.data.req_type == REQ_WRITE);

  always_comb begin
    push_o.push              = accept;
    push_o.item.sample_index = req_i.data.sample_index;
    push_o.item.sample_value = req_i.data.sample_value;
    push_o.item.query_x      = req_i.data.query_x;
    push_o.item.query_z      = req_i.data.query_z;
    if (is_write) begin
      push_o.item.op = OP_WRITE;
    end else if (loaded_q) begin
      push_o.item.op = OP_QUERY;
    end else begin
      push_o.item.op = OP_EMPTY;
    end
    loaded_d = loaded_q || (accept && is_write);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

endmodule

### src/hbs_queue.sv
// Short FIFO between the front end and the execution pipeline.
module hbs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbs_pkg::push_t   push_i,
  input  logic             pop_i,
  output hbs_pkg::item_t   head_o,
  output hbs_pkg::q_stat_t stat_o
);
  import hbs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     cnt_q, cnt_d;

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = push_i.push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (PTR_W+1)'(push_i.push) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      slot_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

### src/hbs_coord.sv
// Four-stage grid coordinate unit for one axis: offset, scale, clamp.
module hbs_coord #(
  parameter int MAX_DIM = 256,
  localparam int DW = $clog2(MAX_DIM + 1)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] q_i,
  input  logic [8:0]         dim_i,
  input  logic [30:0]        cs_i,
  input  logic [30:0]        inv_i,
  output logic [DW-1:0]      cell_o,
  output logic [15:0]        frac_o
);
  import hbs_pkg::*;

  localparam int PW = DW + 33;      // doubled position, signed
  localparam int HW = PW - 1 - 24;  // high slice of the position
  localparam int GW = HW + 39;      // scaled coordinate before clamp

  logic [DW-1:0]        nm1;
  logic signed [PW-1:0] p2;
  logic [GW-1:0]        g;
  logic [GW-1:0]        lim;
  logic [DW+15:0]       coord;

  logic [DW-1:0]        nm1_1_q, nm1_2_q, nm1_3_q;
  logic [DW+30:0]       prod_1_q;
  logic signed [31:0]   q_1_q;
  logic                 pos_2_q, pos_3_q;
  logic [PW-2:0]        p_2_q;
  logic [HW+30:0]       phi_3_q;
  logic [54:0]          plo_3_q;

  assign nm1 = DW'(eff_dim(dim_i, MAX_DIM) - 32'd1);

  always_comb begin
    p2 = $signed({{(PW-33){q_1_q[31]}}, q_1_q, 1'b0})
       + $signed({2'b00, prod_1_q});
    g   = GW'({phi_3_q, 7'b0}) + GW'(plo_3_q[54:17]);
    lim = GW'({nm1_3_q, 16'b0});
    if (!pos_3_q) begin
      coord = '0;
    end else if (g >= lim) begin
      coord = {nm1_3_q - 1'b1, 16'b0};
    end else begin
      coord = g[DW+15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nm1_1_q  <= nm1;
      prod_1_q <= (DW+31)'(nm1) * (DW+31)'(cs_i);
      q_1_q    <= q_i;

      nm1_2_q  <= nm1_1_q;
      pos_2_q  <= !p2[PW-1] && (|p2);
      p_2_q    <= p2[PW-2:0];

      nm1_3_q  <= nm1_2_q;
      pos_3_q  <= pos_2_q;
      phi_3_q  <= (HW+31)'(p_2_q[PW-2:24]) * (HW+31)'(inv_i);
      plo_3_q  <= 55'(p_2_q[23:0]) * 55'(inv_i);

      cell_o   <= coord[DW+15:16];
      frac_o   <= coord[15:0];
    end
  end

endmodule

### src/hbs_back.sv
// Execution pipeline: coordinates, sample store, bilinear blend, gain and output.
module hbs_back #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbs_pkg::cfg_t    cfg_i,
  input  hbs_pkg::item_t   head_i,
  input  hbs_pkg::q_stat_t stat_i,
  output logic             pop_o,
  hbs_stream_if.source     rsp_o
);
  import hbs_pkg::*;

  localparam int DWX   = $clog2(MAX_WIDTH + 1);
  localparam int DWZ   = $clog2(MAX_DEPTH + 1);
  localparam int RW    = (DWX + DWZ > STORE_AW) ? DWX + DWZ : STORE_AW;
  localparam int NSTG  = 9;
  localparam int WSTG  = 5;

  logic en;

  logic [NSTG:1]        vld_q;
  op_e                  op_q  [1:NSTG];
  logic [15:0]          idx_q [1:WSTG];
  logic [7:0]           val_q [1:WSTG];

  logic [DWX-1:0]       cell_x, eff_w;
  logic [DWZ-1:0]       cell_z;
  logic [15:0]          frac_x, frac_z;
  logic [RW-1:0]        row_prod;

  logic [STORE_AW-1:0]  row_5_q;
  logic [DWX-1:0]       x0_5_q;
  logic [15:0]          fx_5_q, fz_5_q, fx_6_q, fz_6_q, fz_7_q;
  logic [STORE_AW-1:0]  a00, a10, a01, a11;

  logic [7:0]           store_top [2**STORE_AW];
  logic [7:0]           store_bot [2**STORE_AW];
  logic [7:0]           h00_q, h10_q, h01_q, h11_q;

  logic signed [8:0]    d0, d1;
  logic signed [25:0]   s0, s1;
  logic [23:0]          h0_7_q, h1_7_q;
  logic signed [24:0]   dh;
  logic signed [41:0]   hsum;
  logic [23:0]          h16_8_q;
  logic signed [56:0]   gprod_9_q;
  logic signed [57:0]   rnd;
  logic signed [41:0]   shr;
  logic signed [31:0]   sat;

  logic                 rsp_valid_q, rsp_valid_d;
  rsp_t                 rsp_data_q, rsp_data_d;

  assign en    = !rsp_valid_q || rsp_o.ready;
  assign pop_o = en && !stat_i.empty;

  hbs_coord #(.MAX_DIM(MAX_WIDTH)) u_coord_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .q_i    (head_i.query_x),
    .dim_i  (cfg_i.map_width),
    .cs_i   (cfg_i.cell_size),
    .inv_i  (cfg_i.inv_cell_size),
    .cell_o (cell_x),
    .frac_o (frac_x)
  );

  hbs_coord #(.MAX_DIM(MAX_DEPTH)) u_coord_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .q_i    (head_i.query_z),
    .dim_i  (cfg_i.map_depth),
    .cs_i   (cfg_i.cell_size),
    .inv_i  (cfg_i.inv_cell_size),
    .cell_o (cell_z),
    .frac_o (frac_z)
  );

  assign eff_w    = DWX'(eff_dim(cfg_i.map_width, MAX_WIDTH));
  assign row_prod = RW'(cell_z) * RW'(eff_w);

  // Row-major neighbor addresses; wrap modulo the store depth.
  assign a00 = row_5_q + STORE_AW'(x0_5_q);
  assign a10 = a00 + 1'b1;
  assign a01 = a00 + STORE_AW'(eff_w);
  assign a11 = a01 + 1'b1;

  always_comb begin
    d0   = $signed({1'b0, h10_q}) - $signed({1'b0, h00_q});
    d1   = $signed({1'b0, h11_q}) - $signed({1'b0, h01_q});
    s0   = $signed({2'b00, h00_q, 16'b0}) + $signed({1'b0, fx_6_q}) * d0;
    s1   = $signed({2'b00, h01_q, 16'b0}) + $signed({1'b0, fx_6_q}) * d1;
    dh   = $signed({1'b0, h1_7_q}) - $signed({1'b0, h0_7_q});
    hsum = $signed({2'b00, h0_7_q, 16'b0}) + $signed({1'b0, fz_7_q}) * dh
         + 42'sd32768;
    rnd  = 58'(gprod_9_q) + 58'sd32768;
    shr  = rnd[57:16];
    // Saturate when the upper bits are not a sign extension.
    if (shr[41:31] == '0 || shr[41:31] == '1) begin
      sat = shr[31:0];
    end else if (shr[41]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_data_d  = rsp_data_q;
    if (en) begin
      rsp_valid_d = vld_q[NSTG] && (op_q[NSTG] != OP_WRITE);
      case (op_q[NSTG])
        OP_QUERY: begin
          rsp_data_d.height_out = sat;
          rsp_data_d.map_loaded = 1'b1;
        end
        default: begin
          rsp_data_d.height_out = '0;
          rsp_data_d.map_loaded = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (en) begin
        vld_q <= {vld_q[NSTG-1:1], pop_o};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
    if (en) begin
      op_q[1]  <= head_i.op;
      idx_q[1] <= head_i.sample_index;
      val_q[1] <= head_i.sample_value;
      for (int k = 2; k <= NSTG; k++) begin
        op_q[k] <= op_q[k-1];
      end
      for (int k = 2; k <= WSTG; k++) begin
        idx_q[k] <= idx_q[k-1];
        val_q[k] <= val_q[k-1];
      end

      row_5_q   <= row_prod[STORE_AW-1:0];
      x0_5_q    <= cell_x;
      fx_5_q    <= frac_x;
      fz_5_q    <= frac_z;

      fx_6_q    <= fx_5_q;
      fz_6_q    <= fz_5_q;

      h0_7_q    <= s0[23:0];
      h1_7_q    <= s1[23:0];
      fz_7_q    <= fz_6_q;

      h16_8_q   <= hsum[39:16];

      gprod_9_q <= $signed({1'b0, h16_8_q}) * $signed(cfg_i.height_gain);
    end
  end

  // Store: two copies, each read at two addresses per cycle. Writes land in
  // the same stage as query reads, so program order is kept.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vld_q[WSTG] && op_q[WSTG] == OP_WRITE) begin
        store_top[idx_q[WSTG]] <= val_q[WSTG];
        store_bot[idx_q[WSTG]] <= val_q[WSTG];
      end
      h00_q <= store_top[a00];
      h10_q <= store_top[a10];
      h01_q <= store_bot[a01];
      h11_q <= store_bot[a11];
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

endmodule

### src/heightmap_bilinear_sampler.sv
// Heightmap bilinear sampler, top level: configuration registers and the
// front end, queue and execution pipeline.
//
// Takes one request beat per cycle while the queue is not full and, with the
// result side ready, returns one query result per cycle. Sample writes travel
// the same pipeline and produce no beat. The
// rate is set by the sample store, kept as two copies that are each read at
// two addresses in the same cycle, so all four neighbors of a query come out
// of one memory stage. A four-entry queue after the front end keeps request
// acceptance going while the result side is stalled. The store is not
// cleared by reset; an entry that was never written reads as an undefined
// value, and no clearing pass runs.
module heightmap_bilinear_sampler #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hbs_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CFG_DW-1:0] cfg_wdata_i,
  hbs_stream_if.sink                 req_i,
  hbs_stream_if.source               rsp_o
);
  import hbs_pkg::*;

  cfg_t    cfg_q, cfg_d;
  push_t   push;
  item_t   head;
  q_stat_t stat;
  logic    pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_WIDTH:   cfg_d.map_width     = cfg_wdata_i[8:0];
        CFG_MAP_DEPTH:   cfg_d.map_depth     = cfg_wdata_i[8:0];
        CFG_CELL_SIZE:   cfg_d.cell_size     = cfg_wdata_i[30:0];
        CFG_INV_CELL:    cfg_d.inv_cell_size = cfg_wdata_i[30:0];
        CFG_HEIGHT_GAIN: cfg_d.height_gain   = $signed(cfg_wdata_i);
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width     <= MAP_DIM_RST;
      cfg_q.map_depth     <= MAP_DIM_RST;
      cfg_q.cell_size     <= CELL_SIZE_RST;
      cfg_q.inv_cell_size <= INV_CELL_RST;
      cfg_q.height_gain   <= GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hbs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (stat),
    .push_o (push)
  );

  hbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  hbs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule

### src/hbs_checker.sv
// Port-level checker for the heightmap bilinear sampler and its bind.
module hbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               req_type_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic signed [31:0] height_i,
  input logic               loaded_i
);
  import hbs_pkg::*;

  logic seen_write_q, seen_write_d;
  logic seen_loaded_q, seen_loaded_d;

  assign seen_write_d  = seen_write_q
                       || (req_valid_i && req_ready_i && req_type_i == REQ_WRITE);
  assign seen_loaded_d = seen_loaded_q || (rsp_valid_i && rsp_ready_i && loaded_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_write_q  <= 1'b0;
      seen_loaded_q <= 1'b0;
    end else begin
      seen_write_q  <= seen_write_d;
      seen_loaded_q <= seen_loaded_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(height_i) && $stable(loaded_i))
    else $error("result beat changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !loaded_i |-> height_i == 32'sd0)
    else $error("unloaded result carries a nonzero height");

  a_loaded_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && loaded_i |-> seen_write_q)
    else $error("loaded result before any sample write");

  a_loaded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && seen_loaded_q |-> loaded_i)
    else $error("loaded flag dropped after a loaded result");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.data.req_type),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .height_i    (rsp_o.data.height_out),
  .loaded_i    (rsp_o.data.map_loaded)
);

### tb/hbs_height_checker.sv
// Height checker: mirrors the grid and registers, predicts each query result and compares.
module hbs_height_checker #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hbs_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [hbs_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  hbs_pkg::req_t              req_data_i,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  hbs_pkg::rsp_t              rsp_data_i,
  output int                         mismatches_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam longint HEIGHT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint HEIGHT_MIN = -64'sh0000_0000_8000_0000;

  bit [7:0]           height_mem [0:(1 << STORE_AW)-1];
  bit                 map_loaded_q;
  logic [8:0]         width_q;
  logic [8:0]         depth_q;
  logic [30:0]        cell_q;
  logic [30:0]        inv_q;
  logic signed [31:0] gain_q;

  rsp_t expected_heights [$];
  int   mismatches = 0;
  int   pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  function automatic int unsigned dim_in_use(logic [8:0] v, int unsigned mx);
    if (v < 9'd2) return 2;
    if (v > mx) return mx;
    return 32'(v);
  endfunction

  // Grid coordinate in Q16.16 from a centered position, clamped one cell short of the edge.
  function automatic logic [31:0] grid_pos(logic signed [31:0] q, int unsigned n);
    longint          p2;
    longint unsigned p;
    longint unsigned inv;
    longint unsigned g;
    longint unsigned lim;
    p2 = 2 * longint'(q) + longint'(n - 1) * longint'(cell_q);
    if (p2 <= 0) return '0;
    p   = p2;
    inv = inv_q;
    // split the product so that it stays inside 64 bits
    g   = (((p >> 24) * inv) << 7) + (((p & 64'hFF_FFFF) * inv) >> 17);
    lim = n - 1;
    lim = lim << 16;
    if (g >= lim) return (n - 2) << 16;
    return g[31:0];
  endfunction

  function automatic rsp_t predict_height(req_t beat);
    rsp_t        res;
    int unsigned w;
    int unsigned d;
    int unsigned x0;
    int unsigned z0;
    int unsigned row0;
    int unsigned row1;
    logic [31:0] gx;
    logic [31:0] gz;
    longint      fx;
    longint      fz;
    longint      h00;
    longint      h10;
    longint      h01;
    longint      h11;
    longint      h0;
    longint      h1;
    longint      h;
    longint      h16;
    longint      gain;
    longint      scaled;
    res.height_out = '0;
    res.map_loaded = 1'b0;
    if (!map_loaded_q) return res;
    w  = dim_in_use(width_q, MAX_WIDTH);
    d  = dim_in_use(depth_q, MAX_DEPTH);
    gx = grid_pos($signed(beat.query_x), w);
    gz = grid_pos($signed(beat.query_z), d);
    x0 = gx[31:16];
    z0 = gz[31:16];
    fx = gx[15:0];
    fz = gz[15:0];
    row0 = z0 * w;
    row1 = (z0 + 1) * w;
    h00 = height_mem[16'(row0 + x0)];
    h10 = height_mem[16'(row0 + x0 + 1)];
    h01 = height_mem[16'(row1 + x0)];
    h11 = height_mem[16'(row1 + x0 + 1)];
    h0  = h00 * 65536 + fx * (h10 - h00);
    h1  = h01 * 65536 + fx * (h11 - h01);
    h   = h0 * 65536 + fz * (h1 - h0);
    h16 = (h + 32768) >>> 16;
    gain   = gain_q;
    scaled = (h16 * gain + 32768) >>> 16;
    if (scaled > HEIGHT_MAX) begin
      scaled = HEIGHT_MAX;
    end else if (scaled < HEIGHT_MIN) begin
      scaled = HEIGHT_MIN;
    end
    res.height_out = scaled[31:0];
    res.map_loaded = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, field, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_t want;
    if (!rst_ni) begin
      map_loaded_q = 1'b0;
      width_q      = MAP_DIM_RST;
      depth_q      = MAP_DIM_RST;
      cell_q       = CELL_SIZE_RST;
      inv_q        = INV_CELL_RST;
      gain_q       = GAIN_RST;
      expected_heights.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_heights.size() == 0) begin
          report_mismatch("result beat with no query pending", rsp_data_i.height_out, '0);
        end else begin
          want = expected_heights.pop_front();
          if (rsp_data_i.height_out !== want.height_out) begin
            report_mismatch("height_out", rsp_data_i.height_out, want.height_out);
          end
          if (rsp_data_i.map_loaded !== want.map_loaded) begin
            report_mismatch("map_loaded", 32'(rsp_data_i.map_loaded), 32'(want.map_loaded));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAP_WIDTH:   width_q = cfg_wdata_i[8:0];
          CFG_MAP_DEPTH:   depth_q = cfg_wdata_i[8:0];
          CFG_CELL_SIZE:   cell_q  = cfg_wdata_i[30:0];
          CFG_INV_CELL:    inv_q   = cfg_wdata_i[30:0];
          CFG_HEIGHT_GAIN: gain_q  = cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        if (req_data_i.req_type == REQ_WRITE) begin
          height_mem[req_data_i.sample_index] = req_data_i.sample_value;
          map_loaded_q = 1'b1;
        end else begin
          expected_heights.insert(expected_heights.size(), predict_height(req_data_i));
        end
      end
    end
    pending = expected_heights.size();
  end

endmodule

### tb/heightmap_bilinear_sampler_tb.sv
// Testbench top for the heightmap sampler: clock, reset, stimulus and verdict.
module heightmap_bilinear_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbs_pkg::*;

  localparam int                GRID_W       = 256;
  localparam int                GRID_D       = 256;
  localparam int                CLK_PERIOD   = 20;
  localparam int                DRAIN_CYCLES = 24;
  localparam int                PHASE_ITEMS  = 28;
  // every grid used keeps width times depth within this loaded prefix
  localparam int                LOAD_SIZE    = 512;
  localparam logic              REQ_QUERY    = 1'b1;
  localparam logic [CFG_AW-1:0] CFG_UNUSED   = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  int height_mismatches;
  int heights_pending;

  // stimulus-side view of the grid, used only to aim query positions
  bit          calm;
  int unsigned cur_w;
  int unsigned cur_d;
  logic [30:0] cur_cell;

  hbs_stream_if #(.T(req_t)) req_ch ();
  hbs_stream_if #(.T(rsp_t)) rsp_ch ();

  heightmap_bilinear_sampler #(
    .MAX_WIDTH(GRID_W),
    .MAX_DEPTH(GRID_D)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  hbs_height_checker #(
    .MAX_WIDTH(GRID_W),
    .MAX_DEPTH(GRID_D)
  ) height_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_data_i  (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_data_i  (rsp_ch.data),
    .mismatches_o(height_mismatches),
    .pending_o   (heights_pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic req_t write_beat(logic [15:0] idx, logic [7:0] val);
    req_t b;
    b.req_type     = REQ_WRITE;
    b.sample_index = idx;
    b.sample_value = val;
    b.query_x      = $urandom;
    b.query_z      = $urandom;
    return b;
  endfunction

  function automatic req_t query_beat(logic [31:0] x, logic [31:0] z);
    req_t b;
    b.req_type     = REQ_QUERY;
    b.sample_index = $urandom;
    b.sample_value = $urandom;
    b.query_x      = x;
    b.query_z      = z;
    return b;
  endfunction

  // Centered position: mostly across the grid and a cell beyond, some at the edges, some anywhere.
  function automatic logic [31:0] pick_pos(int unsigned n);
    longint          half;
    longint          step;
    longint          v;
    longint unsigned r;
    step = cur_cell;
    half = (longint'(n - 1) * step) / 2;
    case ($urandom_range(9, 0))
      0, 1: return $urandom;
      2: v = half;
      3: v = -half;
      default: begin
        r = {$urandom, $urandom};
        v = longint'(r % longint'(2 * half + 2 * step + 1)) - half - step;
      end
    endcase
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    return v[31:0];
  endfunction

  task automatic send_beat(req_t beat);
    int gap;
    gap = calm ? 0 : $urandom_range(5, 0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= beat;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // Hold the request side until every result is back and trailing writes have left the pipe.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (heights_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(logic [31:0] w, logic [31:0] d, logic [31:0] cell_sz,
                            logic [31:0] inv, logic [31:0] gain);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAP_WIDTH;
    cfg_wdata <= w;
    @(negedge clk_i);
    cfg_idx   <= CFG_MAP_DEPTH;
    cfg_wdata <= d;
    @(negedge clk_i);
    cfg_idx   <= CFG_CELL_SIZE;
    cfg_wdata <= cell_sz;
    @(negedge clk_i);
    cfg_idx   <= CFG_INV_CELL;
    cfg_wdata <= inv;
    @(negedge clk_i);
    cfg_idx   <= CFG_HEIGHT_GAIN;
    cfg_wdata <= gain;
    @(negedge clk_i);
    // an index past the register file must change nothing
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= $urandom;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cur_w    = (w[8:0] < 9'd2) ? 2 : ((w[8:0] > GRID_W) ? GRID_W : w[8:0]);
    cur_d    = (d[8:0] < 9'd2) ? 2 : ((d[8:0] > GRID_D) ? GRID_D : d[8:0]);
    cur_cell = cell_sz[30:0];
  endtask

  task automatic random_config();
    logic [31:0] w;
    logic [31:0] d;
    logic [31:0] cell_sz;
    logic [31:0] inv;
    logic [31:0] gain;
    int unsigned wa;
    int unsigned da;
    int unsigned tmp;
    w = $urandom;
    d = $urandom;
    // keep the grid inside the loaded prefix of the store
    wa = ($urandom_range(3, 0) == 0) ? $urandom_range(8, 2) : $urandom_range(256, 2);
    da = $urandom_range(LOAD_SIZE / wa, 2);
    if ($urandom_range(1, 0) == 1) begin
      tmp = wa;
      wa  = da;
      da  = tmp;
    end
    w[8:0] = 9'(wa);
    d[8:0] = 9'(da);
    cell_sz = $urandom;
    cell_sz[30:0] = $urandom_range(1 << 20, 1 << 10);
    inv = $urandom;
    inv[30:0] = 31'((64'h1_0000_0000 / cell_sz[30:0]) + $urandom_range(3, 0));
    case ($urandom_range(2, 0))
      0: gain = $urandom;
      1: begin
        gain = $urandom_range(1024, 0);
        if ($urandom_range(1, 0) == 1) gain = -gain;
      end
      default: gain = GAIN_RST;
    endcase
    set_config(w, d, cell_sz, inv, gain);
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(31, 0) == 0) calm = !calm;
      if ($urandom_range(3, 0) == 0) begin
        send_beat(write_beat($urandom, $urandom));
      end else begin
        send_beat(query_beat(pick_pos(cur_w), pick_pos(cur_d)));
      end
    end
  endtask

  initial begin : rsp_pacing
    int stall;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(5, 0);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    rst_ni       <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_MAP_WIDTH;
    cfg_wdata    <= '0;
    calm     = 1'b0;
    cur_w    = GRID_W;
    cur_d    = GRID_D;
    cur_cell = CELL_SIZE_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // queries before any sample is loaded
    send_beat(query_beat(32'h0000_0000, 32'h0000_0000));
    send_beat(query_beat(32'h8000_0000, 32'h7FFF_FFFF));

    // load the low part of the store back to back; every grid used below fits inside it
    calm = 1'b1;
    for (int i = 0; i < LOAD_SIZE; i++) begin
      send_beat(write_beat(16'(i), 8'($urandom)));
    end
    calm = 1'b0;
    send_beat(write_beat(16'h0000, 8'h00));
    send_beat(write_beat(16'hFFFF, 8'hFF));
    send_beat(write_beat(16'h0001, 8'hFF));
    send_beat(write_beat(16'h0100, 8'hFF));

    // full-width grid two rows deep: origin, far edge, extremes and half-cell fractions
    set_config(32'd256, 32'd2, 32'(CELL_SIZE_RST), 32'(INV_CELL_RST), GAIN_RST);
    send_beat(query_beat(32'h0000_0000, 32'h0000_0000));
    send_beat(query_beat(32'h8000_0000, 32'h8000_0000));
    send_beat(query_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(query_beat(32'hFF80_8000, 32'hFF80_8000));
    send_beat(query_beat(32'h007F_8000, 32'h007F_8000));
    send_beat(query_beat(32'hFF80_8001, 32'h007F_7FFF));
    send_beat(query_beat(32'h0000_8000, 32'hFFFF_8000));
    send_beat(query_beat(32'h7FFF_FFFF, 32'h8000_0000));
    random_items(PHASE_ITEMS);

    // dimensions below the minimum, tiny cells, largest reciprocal and gain
    set_config(32'd0, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_beat(query_beat(32'h0000_0000, 32'h0000_0000));
    send_beat(query_beat(32'h0000_0001, 32'h0000_0001));
    send_beat(query_beat(32'hFFFF_FFFF, 32'h0000_0000));
    random_items(PHASE_ITEMS);

    // width above the maximum, widest cells, smallest reciprocal, most negative gain
    set_config(32'd511, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000);
    send_beat(query_beat(32'h0000_0000, 32'h0000_0000));
    send_beat(query_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    random_items(PHASE_ITEMS);

    // depth above the maximum with the narrowest rows
    set_config(32'd0, 32'd257, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_beat(query_beat(32'h0000_0000, 32'h007F_8000));
    send_beat(query_beat(32'h0000_8000, 32'hFF80_8000));
    random_items(PHASE_ITEMS);

    // zero reciprocal pins every query to the grid origin
    set_config(32'd2, 32'd256, 32'h0001_0000, 32'd0, 32'hFFFF_FFFF);
    send_beat(query_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    random_items(PHASE_ITEMS);

    repeat (6) begin
      random_config();
      random_items(PHASE_ITEMS);
    end

    wait_idle();
    if (height_mismatches == 0) begin
      $display("** heightmap_bilinear_sampler: PASSED **");
    end else begin
      $display("** heightmap_bilinear_sampler: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(50_000 * CLK_PERIOD * 20);
    $display("** heightmap_bilinear_sampler: FAILED **");
    $finish;
  end

endmodule
